FILE: hdl/tdbf_pkg.sv
// ----------------------------------------------------------------------------
// tdbf_pkg - shared types and constants of the tail-drop bit-budget FIFO
// Status codes, descriptor layout and default sizes.
// ----------------------------------------------------------------------------
package tdbf_pkg;

  localparam int unsigned DEPTH_DEF     = 64;
  localparam int unsigned ID_W          = 16;
  localparam int unsigned PKT_BITS_W    = 17;
  localparam int unsigned BUDGET_W      = 24;
  localparam int unsigned CNT_W         = 32;
  localparam logic [BUDGET_W-1:0] MAX_BITS_RST = 24'd65536;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_OVER_BUDGET = 3'd1,
    ST_NOT_DATA    = 3'd2,
    ST_NO_SLOT     = 3'd3,
    ST_EMPTY       = 3'd4
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [PKT_BITS_W-1:0] nbits;
  } desc_t;

endpackage

FILE: hdl/tail_drop_bit_budget_fifo.sv
// ----------------------------------------------------------------------------
// tail_drop_bit_budget_fifo - packet descriptor FIFO with tail drop on bit budget
// Each request passes the request register, then the result register, to out_valid.
// Throughput: one request per cycle; busy stays low, the result strobe cannot stall.
// Head and second descriptors sit in flops; the descriptor RAM prefetches the
// third entry each cycle, so back-to-back dequeues run at full rate.
// Reset (sync, rst_n low): queue empty, counters zero, max_bits 65536.
// ----------------------------------------------------------------------------
module tail_drop_bit_budget_fifo #(
  parameter int unsigned DEPTH = tdbf_pkg::DEPTH_DEF,
  localparam int unsigned HW   = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_command,
  input  logic [tdbf_pkg::ID_W-1:0]         in_packet_id,
  input  logic [tdbf_pkg::PKT_BITS_W-1:0]   in_packet_bits,
  input  logic                              in_is_data,
  // result channel
  output logic                              out_valid,
  output logic [2:0]                        out_status,
  output logic [tdbf_pkg::ID_W-1:0]         out_popped_id,
  output logic [tdbf_pkg::PKT_BITS_W-1:0]   out_popped_bits,
  output logic [tdbf_pkg::BUDGET_W-1:0]     out_queued_bits,
  output logic [HW-1:0]                     out_packets_held,
  output logic                              out_is_empty,
  output logic [tdbf_pkg::ID_W-1:0]         out_head_id,
  output logic [tdbf_pkg::ID_W-1:0]         out_tail_id,
  output logic [tdbf_pkg::CNT_W-1:0]        out_enqueued_total,
  output logic [tdbf_pkg::CNT_W-1:0]        out_dequeued_total,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tdbf_pkg::BUDGET_W-1:0]     cfg_data
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned BW = tdbf_pkg::BUDGET_W;

  // request register
  logic                            req_v_r;
  tdbf_pkg::cmd_t                  req_cmd_r;
  tdbf_pkg::desc_t                 req_desc_r;
  logic                            req_data_r;

  // queue state
  logic [PW-1:0]                   rp_r, rp_nxt;
  logic [PW-1:0]                   wp_r, wp_nxt;
  logic [HW-1:0]                   cnt_r, cnt_nxt;
  logic [BW-1:0]                   qbits_r, qbits_nxt;
  logic [tdbf_pkg::CNT_W-1:0]      enq_r, enq_nxt;
  logic [tdbf_pkg::CNT_W-1:0]      deq_r, deq_nxt;
  tdbf_pkg::desc_t                 h0_r, h0_nxt;
  tdbf_pkg::desc_t                 h1_r, h1_nxt;
  logic [tdbf_pkg::ID_W-1:0]       tail_r, tail_nxt;
  logic [BW-1:0]                   max_bits_r;

  // descriptor RAM
  tdbf_pkg::desc_t                 mem [DEPTH];
  tdbf_pkg::desc_t                 rd_q;
  logic [PW-1:0]                   rd_addr;
  logic [PW:0]                     rd_sum;
  logic                            wr_en;

  // result path
  tdbf_pkg::status_t               status;
  tdbf_pkg::desc_t                 popped;
  logic [BW:0]                     budget_sum;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
    end else begin
      req_v_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_cmd_r        <= tdbf_pkg::cmd_t'(in_command);
      req_desc_r.id    <= in_packet_id;
      req_desc_r.nbits <= in_packet_bits;
      req_data_r       <= in_is_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bits_r <= tdbf_pkg::MAX_BITS_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_bits_r <= cfg_data;
    end
  end

  assign budget_sum = {1'b0, qbits_r} + {{(BW + 1 - tdbf_pkg::PKT_BITS_W){1'b0}},
                                         req_desc_r.nbits};

  always_comb begin
    status    = tdbf_pkg::ST_OK;
    popped    = '0;
    wr_en     = 1'b0;
    rp_nxt    = rp_r;
    wp_nxt    = wp_r;
    cnt_nxt   = cnt_r;
    qbits_nxt = qbits_r;
    enq_nxt   = enq_r;
    deq_nxt   = deq_r;
    h0_nxt    = h0_r;
    h1_nxt    = h1_r;
    tail_nxt  = tail_r;
    if (req_v_r) begin
      case (req_cmd_r)
        tdbf_pkg::CMD_ENQ: begin
          if (!req_data_r) begin
            status = tdbf_pkg::ST_NOT_DATA;
          end else if (budget_sum > {1'b0, max_bits_r}) begin
            status = tdbf_pkg::ST_OVER_BUDGET;
          end else if (cnt_r == HW'(DEPTH)) begin
            status = tdbf_pkg::ST_NO_SLOT;
          end else begin
            wr_en     = 1'b1;
            wp_nxt    = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
            cnt_nxt   = cnt_r + HW'(1);
            qbits_nxt = budget_sum[BW-1:0];
            enq_nxt   = enq_r + tdbf_pkg::CNT_W'(1);
            tail_nxt  = req_desc_r.id;
            // fill the head flops while the queue is shallow
            if (cnt_r == '0) begin
              h0_nxt = req_desc_r;
            end
            if (cnt_r == HW'(1)) begin
              h1_nxt = req_desc_r;
            end
          end
        end
        tdbf_pkg::CMD_DEQ: begin
          if (cnt_r == '0) begin
            status = tdbf_pkg::ST_EMPTY;
          end else begin
            popped    = h0_r;
            rp_nxt    = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
            cnt_nxt   = cnt_r - HW'(1);
            qbits_nxt = qbits_r - {{(BW - tdbf_pkg::PKT_BITS_W){1'b0}}, h0_r.nbits};
            deq_nxt   = deq_r + tdbf_pkg::CNT_W'(1);
            h0_nxt    = h1_r;
            // third entry comes from the prefetched RAM word
            h1_nxt    = rd_q;
          end
        end
        default: begin
          status = tdbf_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r    <= '0;
      wp_r    <= '0;
      cnt_r   <= '0;
      qbits_r <= '0;
      enq_r   <= '0;
      deq_r   <= '0;
    end else begin
      rp_r    <= rp_nxt;
      wp_r    <= wp_nxt;
      cnt_r   <= cnt_nxt;
      qbits_r <= qbits_nxt;
      enq_r   <= enq_nxt;
      deq_r   <= deq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h0_r   <= h0_nxt;
    h1_r   <= h1_nxt;
    tail_r <= tail_nxt;
  end

  // prefetch the entry two behind the next head
  assign rd_sum  = {1'b0, rp_nxt} + (PW + 1)'(2);
  assign rd_addr = (rd_sum >= (PW + 1)'(DEPTH)) ? PW'(rd_sum - (PW + 1)'(DEPTH))
                                               : rd_sum[PW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= req_desc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wp_r == rd_addr)) begin
      rd_q <= req_desc_r;
    end else begin
      rd_q <= mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= req_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req_v_r) begin
      out_status         <= status;
      out_popped_id      <= popped.id;
      out_popped_bits    <= popped.nbits;
      out_queued_bits    <= qbits_nxt;
      out_packets_held   <= cnt_nxt;
      out_is_empty       <= (cnt_nxt == '0);
      out_head_id        <= (cnt_nxt == '0) ? '0 : h0_nxt.id;
      out_tail_id        <= (cnt_nxt == '0) ? '0 : tail_nxt;
      out_enqueued_total <= enq_nxt;
      out_dequeued_total <= deq_nxt;
    end
  end

endmodule

FILE: hdl/tdbf_checker.sv
// ----------------------------------------------------------------------------
// tdbf_checker - port-level checks of the tail-drop bit-budget FIFO
// Watches request/result timing and result consistency.
// ----------------------------------------------------------------------------
module tdbf_checker #(
  parameter int unsigned DEPTH = tdbf_pkg::DEPTH_DEF,
  localparam int unsigned HW   = $clog2(DEPTH + 1)
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic [2:0]                        out_status,
  input logic [tdbf_pkg::ID_W-1:0]         out_popped_id,
  input logic [tdbf_pkg::PKT_BITS_W-1:0]   out_popped_bits,
  input logic [tdbf_pkg::BUDGET_W-1:0]     out_queued_bits,
  input logic [HW-1:0]                     out_packets_held,
  input logic                              out_is_empty,
  input logic [tdbf_pkg::ID_W-1:0]         out_head_id,
  input logic [tdbf_pkg::ID_W-1:0]         out_tail_id
);

  // every accepted request yields a result through the request and result registers
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("request produced no result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == tdbf_pkg::ST_OK || out_status == tdbf_pkg::ST_OVER_BUDGET ||
                   out_status == tdbf_pkg::ST_NOT_DATA || out_status == tdbf_pkg::ST_NO_SLOT ||
                   out_status == tdbf_pkg::ST_EMPTY))
    else $error("undefined status code");

  // an empty queue holds no bits and shows no ids
  a_empty_view: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_packets_held == '0 && out_queued_bits == '0 &&
                                     out_head_id == '0 && out_tail_id == '0))
    else $error("empty queue shows content");

  a_refused_pops_nothing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != tdbf_pkg::ST_OK) |->
      (out_popped_id == '0 && out_popped_bits == '0))
    else $error("refused request returned a descriptor");

endmodule

bind tail_drop_bit_budget_fifo tdbf_checker #(.DEPTH(DEPTH)) u_tdbf_checker (.*);

FILE: bench/tb_tail_drop_bit_budget_fifo.sv
// ----------------------------------------------------------------------------
// tb_tail_drop_bit_budget_fifo - self-checking bench for the bit-budget FIFO
// Drives enqueue and dequeue requests through the start/busy port. A local
// queue model predicts every result, and a checker compares the results in
// order. Directed tests cover admission order, budget edges and a full queue.
// Random traffic then runs under several budget settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tail_drop_bit_budget_fifo;

  localparam int unsigned DEPTH  = tdbf_pkg::DEPTH_DEF;
  localparam int unsigned HELD_W = $clog2(DEPTH + 1);

  typedef struct {
    tdbf_pkg::status_t                   status;
    logic [tdbf_pkg::ID_W-1:0]           popped_id;
    logic [tdbf_pkg::PKT_BITS_W-1:0]     popped_bits;
    logic [tdbf_pkg::BUDGET_W-1:0]       queued_bits;
    logic [HELD_W-1:0]                   packets_held;
    logic                                is_empty;
    logic [tdbf_pkg::ID_W-1:0]           head_id;
    logic [tdbf_pkg::ID_W-1:0]           tail_id;
    logic [tdbf_pkg::CNT_W-1:0]          enq_total;
    logic [tdbf_pkg::CNT_W-1:0]          deq_total;
  } fifo_result_t;

  logic                                clk;
  logic                                rst_n = 1'b0;
  logic                                start = 1'b0;
  logic                                busy;
  logic                                in_command = 1'b0;
  logic [tdbf_pkg::ID_W-1:0]           in_packet_id = '0;
  logic [tdbf_pkg::PKT_BITS_W-1:0]     in_packet_bits = '0;
  logic                                in_is_data = 1'b0;
  logic                                out_valid;
  logic [2:0]                          out_status;
  logic [tdbf_pkg::ID_W-1:0]           out_popped_id;
  logic [tdbf_pkg::PKT_BITS_W-1:0]     out_popped_bits;
  logic [tdbf_pkg::BUDGET_W-1:0]       out_queued_bits;
  logic [HELD_W-1:0]                   out_packets_held;
  logic                                out_is_empty;
  logic [tdbf_pkg::ID_W-1:0]           out_head_id;
  logic [tdbf_pkg::ID_W-1:0]           out_tail_id;
  logic [tdbf_pkg::CNT_W-1:0]          out_enqueued_total;
  logic [tdbf_pkg::CNT_W-1:0]          out_dequeued_total;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [tdbf_pkg::BUDGET_W-1:0]       cfg_data = '0;

  tail_drop_bit_budget_fifo #(.DEPTH(DEPTH)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_packet_id      (in_packet_id),
    .in_packet_bits    (in_packet_bits),
    .in_is_data        (in_is_data),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_popped_id     (out_popped_id),
    .out_popped_bits   (out_popped_bits),
    .out_queued_bits   (out_queued_bits),
    .out_packets_held  (out_packets_held),
    .out_is_empty      (out_is_empty),
    .out_head_id       (out_head_id),
    .out_tail_id       (out_tail_id),
    .out_enqueued_total(out_enqueued_total),
    .out_dequeued_total(out_dequeued_total),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  // Queue model state
  logic [tdbf_pkg::ID_W-1:0]           desc_id_mem   [DEPTH];
  logic [tdbf_pkg::PKT_BITS_W-1:0]     desc_bits_mem [DEPTH];
  int unsigned                         rd_slot;
  int unsigned                         wr_slot;
  int unsigned                         held;
  logic [tdbf_pkg::BUDGET_W-1:0]       bits_held;
  logic [tdbf_pkg::CNT_W-1:0]          enq_count;
  logic [tdbf_pkg::CNT_W-1:0]          deq_count;
  logic [tdbf_pkg::BUDGET_W-1:0]       budget_limit;

  fifo_result_t pending_results[$];
  int           error_count = 0;
  int           burst_left  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic fifo_result_t predict_queue_step(tdbf_pkg::cmd_t cmd,
                                                      logic [tdbf_pkg::ID_W-1:0] id,
                                                      logic [tdbf_pkg::PKT_BITS_W-1:0] nbits,
                                                      logic is_data);
    fifo_result_t r;
    int unsigned  last;
    r.status      = tdbf_pkg::ST_OK;
    r.popped_id   = '0;
    r.popped_bits = '0;
    if (cmd == tdbf_pkg::CMD_ENQ) begin
      // Admission order: type, then budget, then slot space
      if (!is_data)
        r.status = tdbf_pkg::ST_NOT_DATA;
      else if ({1'b0, bits_held} + {8'd0, nbits} > {1'b0, budget_limit})
        r.status = tdbf_pkg::ST_OVER_BUDGET;
      else if (held >= DEPTH)
        r.status = tdbf_pkg::ST_NO_SLOT;
      else begin
        desc_id_mem[wr_slot]   = id;
        desc_bits_mem[wr_slot] = nbits;
        wr_slot   = (wr_slot + 1) % DEPTH;
        held++;
        bits_held = bits_held + tdbf_pkg::BUDGET_W'(nbits);
        enq_count++;
      end
    end else begin
      if (held == 0)
        r.status = tdbf_pkg::ST_EMPTY;
      else begin
        r.popped_id   = desc_id_mem[rd_slot];
        r.popped_bits = desc_bits_mem[rd_slot];
        rd_slot   = (rd_slot + 1) % DEPTH;
        held--;
        bits_held = bits_held - tdbf_pkg::BUDGET_W'(r.popped_bits);
        deq_count++;
      end
    end
    last           = (wr_slot == 0) ? DEPTH - 1 : wr_slot - 1;
    r.queued_bits  = bits_held;
    r.packets_held = held[HELD_W-1:0];
    r.is_empty     = (held == 0);
    r.head_id      = (held != 0) ? desc_id_mem[rd_slot] : '0;
    r.tail_id      = (held != 0) ? desc_id_mem[last] : '0;
    r.enq_total    = enq_count;
    r.deq_total    = deq_count;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Results stay on the ports for one full cycle, so sample mid-cycle
  always @(negedge clk) begin
    fifo_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual status %0d", $time,
                 out_status);
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_status);
        check_field("popped_id", want.popped_id, out_popped_id);
        check_field("popped_bits", want.popped_bits, out_popped_bits);
        check_field("queued_bits", want.queued_bits, out_queued_bits);
        check_field("packets_held", want.packets_held, out_packets_held);
        check_field("is_empty", want.is_empty, out_is_empty);
        check_field("head_id", want.head_id, out_head_id);
        check_field("tail_id", want.tail_id, out_tail_id);
        check_field("enqueued_total", want.enq_total, out_enqueued_total);
        check_field("dequeued_total", want.deq_total, out_dequeued_total);
      end
    end
  end

  // Call right after a rising edge; start stays high for a following request
  task automatic send_request(tdbf_pkg::cmd_t cmd, logic [tdbf_pkg::ID_W-1:0] id,
                              logic [tdbf_pkg::PKT_BITS_W-1:0] nbits, logic is_data);
    logic taken;
    start          <= 1'b1;
    in_command     <= cmd;
    in_packet_id   <= id;
    in_packet_bits <= nbits;
    in_is_data     <= is_data;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
    pending_results.push_back(predict_queue_step(cmd, id, nbits, is_data));
  endtask

  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Hold requests until every result is back, then let the pipeline settle
  task automatic wait_drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_budget(logic [tdbf_pkg::BUDGET_W-1:0] value);
    logic taken;
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end
    cfg_valid    <= 1'b0;
    budget_limit = value;
  endtask

  function automatic logic [tdbf_pkg::PKT_BITS_W-1:0] pick_packet_bits();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return tdbf_pkg::PKT_BITS_W'($urandom_range(0, 131071));
      2: return '1;
      default: return tdbf_pkg::PKT_BITS_W'($urandom_range(1, 4095));
    endcase
  endfunction

  // Bursts of back-to-back requests separated by random gaps
  task automatic pace_sender();
    if (burst_left == 0) begin
      pause_sender($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end else
      burst_left--;
  endtask

  task automatic test_admission_order();
    send_request(tdbf_pkg::CMD_DEQ, '1, '1, 1'b1);
    send_request(tdbf_pkg::CMD_ENQ, '1, '1, 1'b0);
    send_request(tdbf_pkg::CMD_ENQ, 16'hFFFF, '0, 1'b1);
    send_request(tdbf_pkg::CMD_ENQ, 16'h0000, 17'd65536, 1'b1);
    send_request(tdbf_pkg::CMD_ENQ, 16'h5A5A, 17'd1, 1'b1);
    send_request(tdbf_pkg::CMD_ENQ, 16'h1234, '0, 1'b1);
    send_request(tdbf_pkg::CMD_ENQ, 16'hA5A5, '0, 1'b0);
    send_request(tdbf_pkg::CMD_DEQ, 16'h0000, '0, 1'b0);
    send_request(tdbf_pkg::CMD_DEQ, '1, '1, 1'b1);
    send_request(tdbf_pkg::CMD_DEQ, 16'h00FF, 17'h0F0F0, 1'b0);
    send_request(tdbf_pkg::CMD_DEQ, '0, '0, 1'b0);
    wait_drain();
  endtask

  task automatic test_full_queue();
    write_budget('1);
    for (int i = 0; i < DEPTH; i++)
      send_request(tdbf_pkg::CMD_ENQ, tdbf_pkg::ID_W'($urandom_range(0, 65535)), '1, 1'b1);
    send_request(tdbf_pkg::CMD_ENQ, 16'hBEEF, 17'd5, 1'b1);
    send_request(tdbf_pkg::CMD_ENQ, 16'hBEEF, 17'd5, 1'b0);
    // Budget below the held total: nothing drops, budget refusal wins over full
    write_budget('0);
    send_request(tdbf_pkg::CMD_ENQ, 16'hCAFE, 17'd1, 1'b1);
    send_request(tdbf_pkg::CMD_ENQ, 16'hCAFE, '0, 1'b1);
    for (int i = 0; i < DEPTH; i++)
      send_request(tdbf_pkg::CMD_DEQ, tdbf_pkg::ID_W'($urandom_range(0, 65535)),
                   pick_packet_bits(), 1'($urandom_range(0, 1)));
    send_request(tdbf_pkg::CMD_DEQ, '0, '0, 1'b0);
    send_request(tdbf_pkg::CMD_ENQ, 16'h0001, '0, 1'b1);
    send_request(tdbf_pkg::CMD_ENQ, 16'h0002, 17'd1, 1'b1);
    send_request(tdbf_pkg::CMD_DEQ, '0, '0, 1'b0);
    wait_drain();
  endtask

  task automatic test_random_traffic(int requests);
    logic [tdbf_pkg::BUDGET_W-1:0] budgets[5];
    int                            phase_len;
    int                            enq_weight;
    budgets[0] = tdbf_pkg::MAX_BITS_RST;
    budgets[1] = '1;
    budgets[2] = '0;
    budgets[3] = 24'd3000;
    budgets[4] = tdbf_pkg::BUDGET_W'($urandom_range(0, 24'hFFFFFF));
    for (int phase = 0; requests > 0; phase++) begin
      write_budget(budgets[phase % 5]);
      phase_len = 100;
      while (phase_len > 0 && requests > 0) begin
        // Swing between filling and draining to reach full and empty
        enq_weight = ((phase_len / 25) % 2 == 0) ? 8 : 3;
        pace_sender();
        if ($urandom_range(0, 9) < enq_weight)
          send_request(tdbf_pkg::CMD_ENQ, tdbf_pkg::ID_W'($urandom_range(0, 65535)),
                       pick_packet_bits(), $urandom_range(0, 9) != 0);
        else
          send_request(tdbf_pkg::CMD_DEQ, tdbf_pkg::ID_W'($urandom_range(0, 65535)),
                       pick_packet_bits(), 1'($urandom_range(0, 1)));
        phase_len--;
        requests--;
      end
    end
    wait_drain();
  endtask

  initial begin
    rd_slot      = 0;
    wr_slot      = 0;
    held         = 0;
    bits_held    = '0;
    enq_count    = '0;
    deq_count    = '0;
    budget_limit = tdbf_pkg::MAX_BITS_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_admission_order();
    test_full_queue();
    test_random_traffic(1000);

    repeat (6) @(posedge clk);
    error_count += pending_results.size();
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
hdl/tdbf_pkg.sv
hdl/tail_drop_bit_budget_fifo.sv
hdl/tdbf_checker.sv
bench/tb_tail_drop_bit_budget_fifo.sv
